/* design/prur_pkg.sv */
// prur_pkg: shared types, codes and constants for the permutation rank/unrank core
// used by every module in design/; depends on nothing
`timescale 1ns / 1ps

package prur_pkg;

	localparam int LENGTH_DEF = 9;
	localparam int LEN_MAX    = 12;
	localparam int PERM_W     = 36;
	localparam int RANK_W     = 19;
	localparam int SYM_W      = 4;
	localparam int FACT_W     = 64;

	localparam logic OP_RANK   = 1'b0;
	localparam logic OP_UNRANK = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_PERM = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

	typedef struct packed {
		logic              op;
		logic [PERM_W-1:0] perm_in;
		logic [RANK_W-1:0] rank_in;
	} prur_req_t;

	typedef struct packed {
		logic [PERM_W-1:0] perm_out;
		logic [RANK_W-1:0] rank_out;
		logic [1:0]        status;
	} prur_rsp_t;

	// work item carried down the pipeline: sym holds digits, then symbols
	typedef struct packed {
		logic                           op;
		logic [1:0]                     status;
		logic [RANK_W-1:0]              x;
		logic [LEN_MAX-1:0][SYM_W-1:0]  sym;
	} prur_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] digit;
		logic             bad;
	} prur_lane_t;

	function automatic logic [FACT_W-1:0] fact(input int n);
		logic [FACT_W-1:0] f;
		f = FACT_W'(1);
		for (int i = 2; i <= n; i++) begin
			f = f * FACT_W'(i);
		end
		return f;
	endfunction

endpackage

/* design/prur_lane.sv */
// prur_lane: one position of the rank check, counts smaller earlier symbols
// and flags a duplicate or out-of-range symbol; uses prur_pkg
`timescale 1ns / 1ps

module prur_lane import prur_pkg::*; #(
	parameter int LENGTH = LENGTH_DEF,
	parameter int POS    = 0
) (
	input  logic [LEN_MAX-1:0][SYM_W-1:0] sym,
	output prur_lane_t                    lane
);

	always_comb begin
		lane.digit = '0;
		lane.bad   = (sym[POS] >= SYM_W'(LENGTH));
		for (int j = 0; j < LEN_MAX; j++) begin
			if (j < POS) begin
				if (sym[j] == sym[POS]) lane.bad = 1'b1;
				if (sym[j] < sym[POS]) lane.digit = lane.digit + SYM_W'(1);
			end
		end
	end

endmodule

/* design/prur_front.sv */
// prur_front: input stage, unpacks symbols, runs the per-position lanes,
// merges their flags and registers the first work item; uses prur_pkg, prur_lane
`timescale 1ns / 1ps

module prur_front import prur_pkg::*; #(
	parameter int LENGTH = LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	input  prur_req_t  src_item,
	output logic       src_ready,
	output logic       dst_valid,
	output prur_item_t dst_item,
	input  logic       dst_ready
);

	localparam logic [FACT_W-1:0] FACT_LEN = fact(LENGTH);

	logic [LEN_MAX-1:0][SYM_W-1:0] sym;
	prur_lane_t                    lane_res [LEN_MAX];
	logic                          upper_bad;
	logic                          any_bad;
	logic                          range_bad;
	prur_item_t                    nxt;
	prur_item_t                    item_s1;
	logic                          valid_s1;

	for (genvar i = 0; i < LEN_MAX; i++) begin : g_sym
		if (i < LENGTH && SYM_W * i < PERM_W) begin : g_on
			assign sym[i] = src_item.perm_in[SYM_W*i +: SYM_W];
		end else begin : g_off
			assign sym[i] = '0;
		end
	end

	for (genvar i = 0; i < LEN_MAX; i++) begin : g_lane
		if (i < LENGTH) begin : g_on
			prur_lane #(.LENGTH(LENGTH), .POS(i)) u_lane (
				.sym  (sym),
				.lane (lane_res[i])
			);
		end else begin : g_off
			assign lane_res[i] = '0;
		end
	end

	if (SYM_W * LENGTH < PERM_W) begin : g_upper
		assign upper_bad = |src_item.perm_in[PERM_W-1:SYM_W*LENGTH];
	end else begin : g_no_upper
		assign upper_bad = 1'b0;
	end

	assign range_bad = (FACT_W'(src_item.rank_in) >= FACT_LEN);

	always_comb begin
		any_bad = upper_bad;
		for (int i = 0; i < LEN_MAX; i++) begin
			any_bad = any_bad | lane_res[i].bad;
		end
		nxt    = '0;
		nxt.op = src_item.op;
		if (src_item.op == OP_RANK) begin
			nxt.status = any_bad ? ST_NOT_PERM : ST_OK;
			for (int i = 0; i < LEN_MAX; i++) begin
				nxt.sym[i] = lane_res[i].digit;
			end
		end else begin
			nxt.status = range_bad ? ST_RANGE : ST_OK;
			nxt.x      = src_item.rank_in;
		end
	end

	assign src_ready = !valid_s1 || dst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			item_s1 <= nxt;
		end
	end

	assign dst_valid = valid_s1;
	assign dst_item  = item_s1;

endmodule

/* design/prur_digit_stage.sv */
// prur_digit_stage: one factorial digit; unrank peels digit K off the rank,
// rank adds digit K times K factorial; uses prur_pkg
`timescale 1ns / 1ps

module prur_digit_stage import prur_pkg::*; #(
	parameter int K = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	input  prur_item_t src_item,
	output logic       src_ready,
	output logic       dst_valid,
	output prur_item_t dst_item,
	input  logic       dst_ready
);

	localparam logic [FACT_W-1:0] FACT_K = fact(K);

	logic [FACT_W-1:0] x_ext;
	logic [SYM_W-1:0]  dig;
	logic [SYM_W-1:0]  mval;
	logic [FACT_W-1:0] prod;
	logic [RANK_W-1:0] prod_lo;
	prur_item_t        nxt;
	prur_item_t        item_q;
	logic              valid_q;

	always_comb begin
		x_ext = FACT_W'(src_item.x);
		dig   = '0;
		// largest multiple of K! that still fits in the remainder
		for (int m = 1; m < LEN_MAX; m++) begin
			if (m <= K && x_ext >= FACT_W'(m) * FACT_K) dig = SYM_W'(m);
		end
		mval    = (src_item.op == OP_UNRANK) ? dig : src_item.sym[K];
		prod    = FACT_W'(mval) * FACT_K;
		prod_lo = prod[RANK_W-1:0];
		nxt     = src_item;
		if (src_item.status == ST_OK) begin
			if (src_item.op == OP_UNRANK) begin
				nxt.x      = src_item.x - prod_lo;
				nxt.sym[K] = dig;
			end else begin
				nxt.x = src_item.x + prod_lo;
			end
		end
	end

	assign src_ready = !valid_q || dst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (src_ready) begin
			valid_q <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			item_q <= nxt;
		end
	end

	assign dst_valid = valid_q;
	assign dst_item  = item_q;

endmodule

/* design/prur_rebuild_stage.sv */
// prur_rebuild_stage: places position I in unrank mode, bumping every earlier
// symbol at or above it; uses prur_pkg
`timescale 1ns / 1ps

module prur_rebuild_stage import prur_pkg::*; #(
	parameter int I = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	input  prur_item_t src_item,
	output logic       src_ready,
	output logic       dst_valid,
	output prur_item_t dst_item,
	input  logic       dst_ready
);

	prur_item_t nxt;
	prur_item_t item_q;
	logic       valid_q;

	always_comb begin
		nxt = src_item;
		if (src_item.op == OP_UNRANK && src_item.status == ST_OK) begin
			for (int j = 0; j < LEN_MAX; j++) begin
				if (j < I && src_item.sym[j] >= src_item.sym[I]) begin
					nxt.sym[j] = src_item.sym[j] + SYM_W'(1);
				end
			end
		end
	end

	assign src_ready = !valid_q || dst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (src_ready) begin
			valid_q <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			item_q <= nxt;
		end
	end

	assign dst_valid = valid_q;
	assign dst_item  = item_q;

endmodule

/* design/permutation_rank_unrank_core.sv */
// permutation_rank_unrank_core: top level, front lanes, digit and rebuild
// pipelines and the output register; uses prur_pkg and all prur_* modules
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall  req : prur_req_t
//  result    out        rsp_valid / rsp_stall  rsp : prur_rsp_t
//
//  one request per cycle sustained while the result is not stalled, one result
//  per request, in order; the pipeline is the front lanes, LENGTH-1 digit
//  stages, LENGTH-1 rebuild stages and the output register
//  each stage holds one request and moves whenever the stage after it is
//  free, so a stalled result does not stop requests filling empty stages
//  arst_n clears all valid flags; payload registers are not reset

module permutation_rank_unrank_core import prur_pkg::*; #(
	parameter int LENGTH = LENGTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  prur_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output prur_rsp_t rsp
);

	localparam int NSTG  = LENGTH - 1;
	localparam int NODES = 2 * NSTG + 1;

	prur_item_t node_item  [NODES];
	logic       node_valid [NODES];
	logic       node_ready [NODES];
	logic       front_ready;
	prur_rsp_t  fmt;
	prur_rsp_t  rsp_q;
	logic       rsp_valid_q;

	prur_front #(.LENGTH(LENGTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (req_valid),
		.src_item  (req),
		.src_ready (front_ready),
		.dst_valid (node_valid[0]),
		.dst_item  (node_item[0]),
		.dst_ready (node_ready[0])
	);

	assign req_stall = !front_ready;

	// highest digit first
	for (genvar g = 0; g < NSTG; g++) begin : g_digit
		prur_digit_stage #(.K(LENGTH - 1 - g)) u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (node_valid[g]),
			.src_item  (node_item[g]),
			.src_ready (node_ready[g]),
			.dst_valid (node_valid[g+1]),
			.dst_item  (node_item[g+1]),
			.dst_ready (node_ready[g+1])
		);
	end

	for (genvar h = 0; h < NSTG; h++) begin : g_rebuild
		prur_rebuild_stage #(.I(h + 1)) u_rebuild (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (node_valid[NSTG+h]),
			.src_item  (node_item[NSTG+h]),
			.src_ready (node_ready[NSTG+h]),
			.dst_valid (node_valid[NSTG+h+1]),
			.dst_item  (node_item[NSTG+h+1]),
			.dst_ready (node_ready[NSTG+h+1])
		);
	end

	assign node_ready[NODES-1] = !rsp_valid_q || !rsp_stall;

	always_comb begin
		fmt        = '0;
		fmt.status = node_item[NODES-1].status;
		if (node_item[NODES-1].status == ST_OK) begin
			if (node_item[NODES-1].op == OP_UNRANK) begin
				for (int i = 0; i < PERM_W / SYM_W; i++) begin
					if (i < LENGTH) fmt.perm_out[SYM_W*i +: SYM_W] = node_item[NODES-1].sym[i];
				end
			end else begin
				fmt.rank_out = node_item[NODES-1].x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (node_ready[NODES-1]) begin
			rsp_valid_q <= node_valid[NODES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (node_ready[NODES-1] && node_valid[NODES-1]) begin
			rsp_q <= fmt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_NOT_PERM ||
			rsp.status == ST_RANGE))
		else $error("result status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.perm_out == '0 && rsp.rank_out == '0)
		else $error("error result carries nonzero payload");

	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.perm_out == '0 || rsp.rank_out == '0)
		else $error("result carries both a rank and a permutation");

	a_last_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		node_valid[NODES-1] && !node_ready[NODES-1] |=> node_valid[NODES-1])
		else $error("last pipeline stage dropped a blocked request");

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking bench for permutation_rank_unrank_core (lehmer rank and unrank)
// directed table then random requests, scored by an in-bench predictor; uses prur_pkg
`timescale 1ns / 1ps

module tb_top;
	import prur_pkg::*;

	localparam int N = LENGTH_DEF;

	typedef struct packed {
		prur_req_t r;
		logic      fixed;
		prur_rsp_t e;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	prur_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	prur_rsp_t rsp;

	prur_rsp_t pending_rsp_q[$];
	dir_row_t  dir_q[$];
	int        mismatch_cnt = 0;
	int        rsp_cnt = 0;
	int        burst_left = 0;
	bit        hold_on = 1'b0;
	bit        hold_done = 1'b0;

	permutation_rank_unrank_core #(.LENGTH(N)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// expected result of one request
	function automatic prur_rsp_t lehmer_convert(prur_req_t r);
		prur_rsp_t       o;
		int unsigned     sym [LEN_MAX];
		logic [15:0]     seen;
		logic            bad;
		longint unsigned f, acc, x, nfact;
		int unsigned     cnt;
		o = '0;
		bad = 1'b0;
		seen = '0;
		acc = 0;
		if (r.op == OP_RANK) begin
			if (4 * N < PERM_W && (r.perm_in >> (4 * N)) != '0)
				bad = 1'b1;
			for (int i = 0; i < N; i++) begin
				sym[i] = (4 * i < PERM_W) ? int'((r.perm_in >> (4 * i)) & 36'hF) : 0;
				if (sym[i] >= N || seen[sym[i]])
					bad = 1'b1;
				else
					seen[sym[i]] = 1'b1;
			end
			if (bad) begin
				o.status = ST_NOT_PERM;
			end else begin
				f = 1;
				for (int i = 0; i < N; i++) begin
					cnt = 0;
					if (i > 0)
						f = f * i;
					for (int j = 0; j < i; j++)
						if (sym[j] < sym[i])
							cnt++;
					acc = acc + cnt * f;
				end
				o.rank_out = acc[RANK_W-1:0];
				o.status = ST_OK;
			end
		end else begin
			nfact = 1;
			for (int k = 2; k <= N; k++)
				nfact = nfact * k;
			if (longint'(r.rank_in) >= nfact) begin
				o.status = ST_RANGE;
			end else begin
				x = r.rank_in;
				for (int i = N - 1; i >= 0; i--) begin
					f = 1;
					for (int k = 2; k <= i; k++)
						f = f * k;
					sym[i] = int'(x / f);
					x = x % f;
				end
				// each new symbol pushes up every earlier one at or above it
				for (int i = 0; i < N; i++)
					for (int j = 0; j < i; j++)
						if (sym[j] >= sym[i])
							sym[j]++;
				for (int i = 0; i < N; i++)
					if (4 * i < PERM_W)
						o.perm_out = o.perm_out | (PERM_W'(sym[i] & 4'hF) << (4 * i));
				o.status = ST_OK;
			end
		end
		return o;
	endfunction

	task automatic add_row(input logic op, input logic [PERM_W-1:0] perm,
			input logic [RANK_W-1:0] rank, input logic fixed,
			input logic [PERM_W-1:0] e_perm, input logic [RANK_W-1:0] e_rank,
			input logic [1:0] e_st);
		dir_row_t row;
		row.r.op = op;
		row.r.perm_in = perm;
		row.r.rank_in = rank;
		row.fixed = fixed;
		row.e.perm_out = e_perm;
		row.e.rank_out = e_rank;
		row.e.status = e_st;
		dir_q.push_back(row);
	endtask

	// sender bursts with random gaps; no gaps while the receiver holds off
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (hold_on)
				gap = 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send(input prur_req_t r, input logic fixed, input prur_rsp_t e);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pending_rsp_q.push_back(fixed ? e : lehmer_convert(r));
	endtask

	task automatic shuffle_perm(output logic [PERM_W-1:0] p);
		int a [LEN_MAX];
		int k, t;
		for (int i = 0; i < N; i++)
			a[i] = i;
		for (int i = N - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			t = a[i];
			a[i] = a[k];
			a[k] = t;
		end
		p = '0;
		for (int i = 0; i < N; i++)
			p = p | (PERM_W'(a[i]) << (4 * i));
	endtask

	task automatic rand_req(output prur_req_t r);
		int kind, pa, pb;
		logic [PERM_W-1:0] p;
		kind = $urandom_range(0, 99);
		r.rank_in = RANK_W'($urandom());
		r.perm_in = PERM_W'({$urandom(), $urandom()});
		if (kind < 40) begin
			r.op = OP_RANK;
			shuffle_perm(r.perm_in);
		end else if (kind < 55) begin
			// broken permutation: bad nibble, oversized symbol or duplicate
			r.op = OP_RANK;
			shuffle_perm(p);
			pa = $urandom_range(0, N - 1);
			pb = $urandom_range(0, N - 1);
			case ($urandom_range(0, 2))
				0: p[4*pa +: 4] = 4'($urandom());
				1: p[4*pa +: 4] = 4'($urandom_range(N, 15));
				default: p[4*pa +: 4] = p[4*pb +: 4];
			endcase
			r.perm_in = p;
		end else if (kind < 90) begin
			r.op = OP_UNRANK;
			r.rank_in = RANK_W'($urandom_range(0, 362879));
		end else begin
			r.op = 1'($urandom());
		end
	endtask

	// receiver: changing stall patterns plus one long hold-off
	initial begin
		int mode, left, cyc;
		mode = 0;
		left = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (!hold_done && rsp_cnt >= 60) begin
				hold_on = 1'b1;
				rsp_stall <= 1'b1;
				repeat (150) @(posedge clk);
				hold_on = 1'b0;
				hold_done = 1'b1;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 80);
				end
				left--;
				cyc++;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					2: rsp_stall <= ((cyc % 5) >= 3);
					default: rsp_stall <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		prur_rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_cnt++;
			if (pending_rsp_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result: perm %h rank %0d status %0d",
						rsp.perm_out, rsp.rank_out, rsp.status);
			end else begin
				e = pending_rsp_q.pop_front();
				if (rsp.perm_out !== e.perm_out || rsp.rank_out !== e.rank_out ||
						rsp.status !== e.status) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: exp perm %h rank %0d status %0d, got perm %h rank %0d status %0d",
							e.perm_out, e.rank_out, e.status,
							rsp.perm_out, rsp.rank_out, rsp.status);
				end
			end
		end
	end

	initial begin
		prur_req_t r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// identity has the top rank, reversed order rank zero
		add_row(OP_RANK, 36'h876543210, 19'd0, 1'b1, '0, 19'd362879, ST_OK);
		add_row(OP_RANK, 36'h012345678, 19'd0, 1'b1, '0, 19'd0, ST_OK);
		add_row(OP_RANK, 36'h876543210, 19'h7FFFF, 1'b1, '0, 19'd362879, ST_OK);
		add_row(OP_RANK, 36'hFFFFFFFFF, 19'd0, 1'b1, '0, 19'd0, ST_NOT_PERM);
		add_row(OP_RANK, 36'h000000000, 19'h7FFFF, 1'b1, '0, 19'd0, ST_NOT_PERM);
		add_row(OP_RANK, 36'h876543219, 19'd0, 1'b1, '0, 19'd0, ST_NOT_PERM);
		add_row(OP_RANK, 36'h876543211, 19'd0, 1'b1, '0, 19'd0, ST_NOT_PERM);
		add_row(OP_RANK, 36'hF76543210, 19'd0, 1'b1, '0, 19'd0, ST_NOT_PERM);
		add_row(OP_RANK, 36'h876543201, 19'd5, 1'b0, '0, '0, ST_OK);
		add_row(OP_RANK, 36'h102345678, 19'd0, 1'b0, '0, '0, ST_OK);
		add_row(OP_RANK, 36'h381726540, 19'd0, 1'b0, '0, '0, ST_OK);
		add_row(OP_RANK, 36'h345678012, 19'd0, 1'b0, '0, '0, ST_OK);
		add_row(OP_UNRANK, 36'h0, 19'd0, 1'b1, 36'h012345678, 19'd0, ST_OK);
		add_row(OP_UNRANK, 36'h0, 19'd362879, 1'b1, 36'h876543210, 19'd0, ST_OK);
		add_row(OP_UNRANK, 36'h0, 19'd362880, 1'b1, '0, 19'd0, ST_RANGE);
		add_row(OP_UNRANK, 36'hFFFFFFFFF, 19'h7FFFF, 1'b1, '0, 19'd0, ST_RANGE);
		add_row(OP_UNRANK, 36'hFFFFFFFFF, 19'd0, 1'b1, 36'h012345678, 19'd0, ST_OK);
		add_row(OP_UNRANK, 36'h0, 19'd1, 1'b0, '0, '0, ST_OK);
		add_row(OP_UNRANK, 36'h0, 19'd40320, 1'b0, '0, '0, ST_OK);
		add_row(OP_UNRANK, 36'h0, 19'd181440, 1'b0, '0, '0, ST_OK);
		add_row(OP_UNRANK, 36'h0, 19'd362878, 1'b0, '0, '0, ST_OK);

		foreach (dir_q[i]) begin
			pace();
			send(dir_q[i].r, dir_q[i].fixed, dir_q[i].e);
		end

		for (int n = 0; n < 550; n++) begin
			rand_req(r);
			pace();
			send(r, 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (2 * N + 8) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
design/prur_pkg.sv
design/prur_lane.sv
design/prur_front.sv
design/prur_digit_stage.sv
design/prur_rebuild_stage.sv
design/permutation_rank_unrank_core.sv
dv/tb_top.sv
